[hw/rtl/fwrrm_pkg.sv]
// ----------------------------------------------------------------------------
// fwrrm_pkg
// Shared types and constants for the firewall range rule table.
// ----------------------------------------------------------------------------
package fwrrm_pkg;

  localparam int MAX_RULES_DEF = 64;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [1:0] DIR_IN    = 2'd0;
  localparam logic [1:0] DIR_OUT   = 2'd1;
  localparam logic [1:0] PROTO_TCP = 2'd0;
  localparam logic [1:0] PROTO_UDP = 2'd1;

  // cls: bit 0 outbound, bit 1 udp
  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] port_hi;
    logic [15:0] port_lo;
    logic [31:0] addr_hi;
    logic [31:0] addr_lo;
  } rule_t;

  typedef struct packed {
    logic add;
    logic reject;
    logic scan_start;
    logic scan_step;
    logic scan_end;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic class_ok;
    logic empty;
    logic issue;
    logic hit;
  } dp_status_t;

endpackage

[hw/rtl/fwrrm_ram.sv]
// ----------------------------------------------------------------------------
// fwrrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwrrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/fwrrm_dp.sv]
// ----------------------------------------------------------------------------
// fwrrm_dp
// Datapath: rule store, fill count, scan index, range compare, result beat.
// ----------------------------------------------------------------------------
module fwrrm_dp #(
  parameter int MAX_RULES = fwrrm_pkg::MAX_RULES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fwrrm_pkg::dp_cmd_t     cmd_in,
  output fwrrm_pkg::dp_status_t  st,
  input  logic                   cmd,
  input  logic [1:0]             direction,
  input  logic [1:0]             protocol,
  input  logic [15:0]            port_low,
  input  logic [15:0]            port_high,
  input  logic [31:0]            addr_low,
  input  logic [31:0]            addr_high,
  input  logic [15:0]            packet_port,
  input  logic [31:0]            packet_addr,
  output logic                   done,
  output logic                   accepted,
  output logic                   table_full
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RULE_W = $bits(fwrrm_pkg::rule_t);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic                cmp_v;
  logic [1:0]          pkt_cls;
  logic [15:0]         pkt_port;
  logic [31:0]         pkt_addr;
  logic                full;
  logic                we;
  fwrrm_pkg::rule_t    wrule;
  fwrrm_pkg::rule_t    rrule;
  logic [RULE_W-1:0]   rdata;
  logic [IDX_W-1:0]    waddr;
  logic [IDX_W-1:0]    raddr;
  logic                match;

  assign full  = (count >= CNT_W'(MAX_RULES));
  assign we    = cmd_in.add && !full;
  assign waddr = count[IDX_W-1:0];
  assign raddr = idx[IDX_W-1:0];

  always_comb begin
    wrule.cls[0]  = (direction == fwrrm_pkg::DIR_OUT);
    wrule.cls[1]  = (protocol != fwrrm_pkg::PROTO_TCP);
    wrule.port_hi = port_high;
    wrule.port_lo = port_low;
    wrule.addr_hi = addr_high;
    wrule.addr_lo = addr_low;
  end

  fwrrm_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrule),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rrule = rdata;

  always_comb begin
    match = (rrule.cls == pkt_cls) &&
            (pkt_port >= rrule.port_lo) && (pkt_port <= rrule.port_hi) &&
            (pkt_addr >= rrule.addr_lo) && (pkt_addr <= rrule.addr_hi);
  end

  always_comb begin
    st.is_add   = (cmd == fwrrm_pkg::CMD_ADD);
    st.class_ok = ((direction == fwrrm_pkg::DIR_IN) || (direction == fwrrm_pkg::DIR_OUT)) &&
                  ((protocol == fwrrm_pkg::PROTO_TCP) || (protocol == fwrrm_pkg::PROTO_UDP));
    st.empty    = (count == '0);
    st.issue    = (idx < count);
    st.hit      = cmp_v && match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      cmp_v      <= 1'b0;
      done       <= 1'b0;
      accepted   <= 1'b0;
      table_full <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd_in.add) begin
        if (!full) begin
          count <= count + CNT_W'(1);
        end
        done       <= 1'b1;
        accepted   <= 1'b0;
        table_full <= full;
      end
      if (cmd_in.reject) begin
        done       <= 1'b1;
        accepted   <= 1'b0;
        table_full <= 1'b0;
      end
      if (cmd_in.scan_start) begin
        idx   <= '0;
        cmp_v <= 1'b0;
      end
      if (cmd_in.scan_step) begin
        if (st.issue) begin
          idx <= idx + CNT_W'(1);
        end
        cmp_v <= st.issue;
      end
      if (cmd_in.scan_end) begin
        done       <= 1'b1;
        accepted   <= st.hit;
        table_full <= 1'b0;
      end
    end
  end

  // packet held for the scan
  always_ff @(posedge clk) begin
    if (cmd_in.scan_start) begin
      pkt_cls  <= {protocol[0], direction[0]};
      pkt_port <= packet_port;
      pkt_addr <= packet_addr;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RULES))
    else $error("rule count past capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CNT_W'(1)))
    else $error("rule count moved by more than one");

  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> !accepted)
    else $error("table_full outside an add result");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    cmd_in.scan_step |-> (idx <= count))
    else $error("scan index beyond stored rules");
`endif

endmodule

[hw/rtl/fwrrm_ctrl.sv]
// ----------------------------------------------------------------------------
// fwrrm_ctrl
// Controller: accepts a beat, sequences the table scan for checks.
// ----------------------------------------------------------------------------
module fwrrm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  fwrrm_pkg::dp_status_t  st,
  output fwrrm_pkg::dp_cmd_t     cmd_out
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd_out    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (st.is_add) begin
            cmd_out.add = 1'b1;
          end else if (!st.class_ok || st.empty) begin
            cmd_out.reject = 1'b1;
          end else begin
            cmd_out.scan_start = 1'b1;
            state_next         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_out.scan_step = 1'b1;
        if (st.hit || !st.issue) begin
          cmd_out.scan_end = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next == S_SCAN);
    end
  end

`ifndef SYNTHESIS
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state == S_SCAN))
    else $error("busy out of step with scan");

  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("scan began without a beat");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    cmd_out.scan_end |=> !busy)
    else $error("still busy after scan end");
`endif

endmodule

[hw/rtl/firewall_range_rule_match.sv]
// ----------------------------------------------------------------------------
// firewall_range_rule_match
// Access-control table of port and IPv4 address range rules, with add and
// check commands and a linear scan of the stored rules.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  command  | start, busy        | cmd, direction, protocol, port_low,
//           |                    | port_high, addr_low, addr_high,
//           |                    | packet_port, packet_addr
//  result   | done (1-cycle)     | accepted, table_full
//
//  A beat is taken when start is high and busy is low.
//  Add, and a check that is rejected outright or meets an empty table: done
//  the cycle after the beat; busy stays low.
//  Other checks: one rule compare per cycle from the rule RAM, done once the
//  last stored rule is compared, or earlier on a hit; busy meanwhile.
//  Synchronous reset empties the table; no clearing pass.
//  The result beat cannot be stalled.
// ----------------------------------------------------------------------------
module firewall_range_rule_match #(
  parameter int MAX_RULES = fwrrm_pkg::MAX_RULES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [1:0]  direction,
  input  logic [1:0]  protocol,
  input  logic [15:0] port_low,
  input  logic [15:0] port_high,
  input  logic [31:0] addr_low,
  input  logic [31:0] addr_high,
  input  logic [15:0] packet_port,
  input  logic [31:0] packet_addr,
  output logic        done,
  output logic        accepted,
  output logic        table_full
);

  fwrrm_pkg::dp_cmd_t    dp_cmd;
  fwrrm_pkg::dp_status_t dp_st;

  fwrrm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .st      (dp_st),
    .cmd_out (dp_cmd)
  );

  fwrrm_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_in      (dp_cmd),
    .st          (dp_st),
    .cmd         (cmd),
    .direction   (direction),
    .protocol    (protocol),
    .port_low    (port_low),
    .port_high   (port_high),
    .addr_low    (addr_low),
    .addr_high   (addr_high),
    .packet_port (packet_port),
    .packet_addr (packet_addr),
    .done        (done),
    .accepted    (accepted),
    .table_full  (table_full)
  );

endmodule
